/* rtl/pixel_bbox_compensated_expand_top_macros.svh */
// ----------------------------------------------------------------------------
// pixel_bbox_compensated_expand_top_macros.svh
// Assertion macros used by the checker of the bounding box block.
// ----------------------------------------------------------------------------
`ifndef PIXEL_BBOX_COMPENSATED_EXPAND_TOP_MACROS_SVH
`define PIXEL_BBOX_COMPENSATED_EXPAND_TOP_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define PBCE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted
`define PBCE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also checks across reset
`define PBCE_ASSERT_RST_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pbce_pkg.sv */
// ----------------------------------------------------------------------------
// pbce_pkg
// Types and constants of the compensated bounding box expansion block.
// ----------------------------------------------------------------------------
package pbce_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int COORD_W   = 13;
    localparam int MARGIN_W  = 12;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 4;
    localparam int SHORT_SAT = (1 << COORD_W) - 1;

    // Register reset values
    localparam logic [COORD_W-1:0]  GRID_RESET   = COORD_W'(MAX_DIM % (1 << COORD_W));
    localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(5);

    // Register indexes (word address)
    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MARGIN      = 2'd2;

    typedef struct packed {
        logic [COORD_W-1:0] pixel_row;
        logic [COORD_W-1:0] pixel_col;
        logic               last_pixel;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] box_row_min;
        logic [COORD_W-1:0] box_col_min;
        logic [COORD_W-1:0] box_row_max;
        logic [COORD_W-1:0] box_col_max;
        logic [COORD_W-1:0] left_shortfall;
        logic [COORD_W-1:0] right_shortfall;
        logic [COORD_W-1:0] top_shortfall;
        logic [COORD_W-1:0] bottom_shortfall;
    } out_item_t;

    typedef struct packed {
        logic [COORD_W-1:0]  grid_width;
        logic [COORD_W-1:0]  grid_height;
        logic [MARGIN_W-1:0] margin;
    } cfg_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accum;
        logic calc_def;
        logic calc_sum;
        logic load_out;
    } cmd_t;

endpackage

/* rtl/pbce_regs.sv */
// ----------------------------------------------------------------------------
// pbce_regs
// APB configuration registers: grid width, grid height and margin.
// ----------------------------------------------------------------------------
module pbce_regs (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pbce_pkg::ADDR_W-1:0] paddr,
    input  logic [pbce_pkg::DATA_W-1:0] pwdata,
    output logic [pbce_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output pbce_pkg::cfg_t              cfg
);

    pbce_pkg::cfg_t cfg_reg;
    logic           wr_en;
    logic [1:0]     reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // Write the addressed register, drop writes past the list
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.grid_width  <= pbce_pkg::GRID_RESET;
            cfg_reg.grid_height <= pbce_pkg::GRID_RESET;
            cfg_reg.margin      <= pbce_pkg::MARGIN_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                pbce_pkg::REG_GRID_WIDTH:  cfg_reg.grid_width  <= pwdata[pbce_pkg::COORD_W-1:0];
                pbce_pkg::REG_GRID_HEIGHT: cfg_reg.grid_height <= pwdata[pbce_pkg::COORD_W-1:0];
                pbce_pkg::REG_MARGIN:      cfg_reg.margin      <= pwdata[pbce_pkg::MARGIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        unique case (reg_idx)
            pbce_pkg::REG_GRID_WIDTH:
                prdata = pbce_pkg::DATA_W'(cfg_reg.grid_width);
            pbce_pkg::REG_GRID_HEIGHT:
                prdata = pbce_pkg::DATA_W'(cfg_reg.grid_height);
            pbce_pkg::REG_MARGIN:
                prdata = pbce_pkg::DATA_W'(cfg_reg.margin);
            default:
                prdata = '0;
        endcase
    end

endmodule

/* rtl/pbce_datapath.sv */
// ----------------------------------------------------------------------------
// pbce_datapath
// Min/max accumulators, three-step box expansion and the result register.
// ----------------------------------------------------------------------------
module pbce_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  pbce_pkg::cmd_t      cmd,
    input  pbce_pkg::cfg_t      cfg,
    input  pbce_pkg::in_item_t  in_item,
    output pbce_pkg::out_item_t out_item
);

    localparam int CW = pbce_pkg::COORD_W;
    localparam int SW = CW + 4;

    typedef logic signed [SW-1:0] sval_t;

    // Axis 0 is columns, axis 1 is rows
    logic [CW-1:0]       acc_min_reg [2];
    logic [CW-1:0]       acc_max_reg [2];
    logic [CW-1:0]       pix [2];
    sval_t               def_lo_reg [2];
    sval_t               def_hi_reg [2];
    sval_t               def_lo_next [2];
    sval_t               def_hi_next [2];
    sval_t               a_raw_reg [2];
    sval_t               b_raw_reg [2];
    sval_t               a_raw_next [2];
    sval_t               b_raw_next [2];
    logic [CW-1:0]       edge_lo [2];
    logic [CW-1:0]       edge_hi [2];
    logic [CW-1:0]       short_lo [2];
    logic [CW-1:0]       short_hi [2];
    logic [CW-1:0]       size [2];
    sval_t               m_s;
    pbce_pkg::out_item_t out_reg;

    function automatic sval_t ext(input logic [CW-1:0] v);
        return sval_t'({4'b0, v});
    endfunction

    function automatic logic [CW-1:0] sat(input sval_t v);
        return (v > sval_t'(pbce_pkg::SHORT_SAT)) ? CW'(pbce_pkg::SHORT_SAT) : v[CW-1:0];
    endfunction

    assign pix[0]  = in_item.pixel_col;
    assign pix[1]  = in_item.pixel_row;
    assign size[0] = cfg.grid_width;
    assign size[1] = cfg.grid_height;
    assign m_s     = sval_t'({5'b0, cfg.margin});

    // Per-axis arithmetic: shortfalls, raw edges, then clamp and flip guard
    always_comb begin
        sval_t d_lo;
        sval_t d_hi;
        sval_t a;
        sval_t b;
        for (int i = 0; i < 2; i++) begin
            d_lo = m_s + sval_t'(1) - ext(acc_min_reg[i]);
            d_hi = m_s - ext(size[i]) + ext(acc_max_reg[i]);
            def_lo_next[i] = (d_lo < 0) ? '0 : d_lo;
            def_hi_next[i] = (d_hi < 0) ? '0 : d_hi;
            a_raw_next[i]  = ext(acc_min_reg[i]) - (m_s + def_hi_reg[i]);
            b_raw_next[i]  = ext(acc_max_reg[i]) + (m_s + def_lo_reg[i]);
            a = (a_raw_reg[i] < sval_t'(1)) ? sval_t'(1) : a_raw_reg[i];
            b = (b_raw_reg[i] > ext(size[i])) ? ext(size[i]) : b_raw_reg[i];
            if (a > b) begin
                a = sval_t'(1);
                b = ext(size[i]);
            end
            edge_lo[i]  = a[CW-1:0];
            edge_hi[i]  = b[CW-1:0];
            short_lo[i] = sat(def_lo_reg[i]);
            short_hi[i] = sat(def_hi_reg[i]);
        end
    end

    // Fold pixels into the accumulators, re-arm them when a result loads
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 2; i++) begin
                acc_min_reg[i] <= '1;
                acc_max_reg[i] <= '0;
            end
        end else if (cmd.load_out) begin
            for (int i = 0; i < 2; i++) begin
                acc_min_reg[i] <= '1;
                acc_max_reg[i] <= '0;
            end
        end else if (cmd.accum) begin
            for (int i = 0; i < 2; i++) begin
                if (pix[i] < acc_min_reg[i]) acc_min_reg[i] <= pix[i];
                if (pix[i] > acc_max_reg[i]) acc_max_reg[i] <= pix[i];
            end
        end
    end

    // Intermediate and result registers, no reset needed
    always_ff @(posedge aclk) begin
        if (cmd.calc_def) begin
            for (int i = 0; i < 2; i++) begin
                def_lo_reg[i] <= def_lo_next[i];
                def_hi_reg[i] <= def_hi_next[i];
            end
        end
        if (cmd.calc_sum) begin
            for (int i = 0; i < 2; i++) begin
                a_raw_reg[i] <= a_raw_next[i];
                b_raw_reg[i] <= b_raw_next[i];
            end
        end
        if (cmd.load_out) begin
            out_reg.box_row_min      <= edge_lo[1];
            out_reg.box_col_min      <= edge_lo[0];
            out_reg.box_row_max      <= edge_hi[1];
            out_reg.box_col_max      <= edge_hi[0];
            out_reg.left_shortfall   <= short_lo[0];
            out_reg.right_shortfall  <= short_hi[0];
            out_reg.top_shortfall    <= short_lo[1];
            out_reg.bottom_shortfall <= short_hi[1];
        end
    end

    assign out_item = out_reg;

endmodule

/* rtl/pbce_ctrl.sv */
// ----------------------------------------------------------------------------
// pbce_ctrl
// Sequencer: accumulate, then shortfall, sum and clamp steps per area.
// ----------------------------------------------------------------------------
module pbce_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    input  logic           s_last,
    output logic           s_ready,
    output logic           m_valid,
    input  logic           m_ready,
    output pbce_pkg::cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_ACC,
        ST_DEF,
        ST_SUM,
        ST_CLAMP
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   accept;
    logic   load;

    assign s_ready = (state_reg == ST_ACC);
    assign accept  = s_valid & s_ready;
    assign load    = (state_reg == ST_CLAMP) & (~m_valid_reg | m_ready);
    assign m_valid = m_valid_reg;

    assign cmd.accum    = accept;
    assign cmd.calc_def = (state_reg == ST_DEF);
    assign cmd.calc_sum = (state_reg == ST_SUM);
    assign cmd.load_out = load;

    // Advance on the last pixel, hold in clamp while the result slot is full and not taken
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACC:   if (accept && s_last) state_next = ST_DEF;
            ST_DEF:   state_next = ST_SUM;
            ST_SUM:   state_next = ST_CLAMP;
            ST_CLAMP: if (load) state_next = ST_ACC;
            default:  state_next = ST_ACC;
        endcase
    end

    // State and result valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACC;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* rtl/pixel_bbox_compensated_expand_top.sv */
// A pixel without the last marker is taken and gives no item.
// Throughput: one pixel per cycle while an area accumulates.
// A last pixel gives its item after the shortfall, sum and clamp steps, in that order;
// no pixel is taken during those steps, and the clamp step holds while an earlier item waits.
// Reset: synchronous active-low aresetn re-arms the accumulators, loads the register
// defaults (grid 4096 by 4096, margin 5) and drops any pending item.
// ----------------------------------------------------------------------------
// pixel_bbox_compensated_expand_top
// Pixel bounding box with margin expansion and opposite-side compensation.
// ----------------------------------------------------------------------------
module pixel_bbox_compensated_expand_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  pbce_pkg::in_item_t          s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output pbce_pkg::out_item_t         m_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [pbce_pkg::ADDR_W-1:0] paddr,
    input  logic [pbce_pkg::DATA_W-1:0] pwdata,
    output logic [pbce_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);

    pbce_pkg::cfg_t cfg;
    pbce_pkg::cmd_t cmd;

    // Configuration registers
    pbce_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer
    pbce_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_last  (s_data.last_pixel),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // Accumulators and expansion arithmetic
    pbce_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .cfg      (cfg),
        .in_item  (s_data),
        .out_item (m_data)
    );

endmodule

/* rtl/pbce_checker.sv */
// ----------------------------------------------------------------------------
// pbce_checker
// Port-level checks of the bounding box block, bound to the top level.
// ----------------------------------------------------------------------------
`include "pixel_bbox_compensated_expand_top_macros.svh"

module pbce_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input pbce_pkg::in_item_t  s_data,
    input logic                m_valid,
    input logic                m_ready,
    input pbce_pkg::out_item_t m_data
);

    // A stalled item holds
    `PBCE_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_data), "stalled item changed")

    // The block is busy right after a last pixel
    `PBCE_ASSERT_NEXT(a_busy_after_last, s_valid && s_ready && s_data.last_pixel, !s_ready, "pixel taken during expansion")

    // A left or top shortfall pins that edge to the first column or row
    `PBCE_ASSERT_IMP(a_left_edge, m_valid && (m_data.left_shortfall != 0), m_data.box_col_min == 1, "left shortfall without left edge at 1")
    `PBCE_ASSERT_IMP(a_top_edge, m_valid && (m_data.top_shortfall != 0), m_data.box_row_min == 1, "top shortfall without top edge at 1")

    // Reset drops any pending item
    `PBCE_ASSERT_RST_NEXT(a_reset_clear, !aresetn, !m_valid, "item valid after reset")

endmodule

bind pixel_bbox_compensated_expand_top pbce_checker u_pbce_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
